// ----- rtl/cbbd_pkg.sv -----
// Shared types, codes and sizes for the character buffer with range delete.
// Used by cbbd_ram, cbbd_ctrl and char_buffer_block_delete; no dependencies.
package cbbd_pkg;

    localparam int DEPTH  = 256;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = ADDR_W + 1;

    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;
    localparam logic [1:0] OP_READ   = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_BAD  = 2'd2;

    // Request to the byte memory: one write and one registered read per cycle.
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [7:0]        wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } mem_req_t;

    // Finished result handed from the sequencer to the output register.
    typedef struct packed {
        logic [7:0]       read_char;
        logic [CNT_W-1:0] length;
        logic [1:0]       status;
    } result_t;

endpackage

// ----- rtl/char_buffer_block_delete.sv -----
// Top level of the character buffer with range delete: stream ports, the
// output register and the instances of cbbd_ctrl and cbbd_ram.
// Depends on cbbd_pkg, cbbd_ctrl and cbbd_ram.
//
// Usage: each beat on the s_ channel carries one command (append, delete a
// block, remove every copy of a byte, read a position). Each command gives
// exactly one result beat on the m_ channel with the byte read, the length
// after the command and a status code.
// Append and rejected commands pass from acceptance through the start step
// to the result register; a read adds a registered memory read. Delete and
// remove walk the store one entry at a time (a registered memory read, then
// the conditional write), so their time grows with the entries moved or
// scanned, at most DEPTH. The single-port-pair byte memory sets this pace.
// Throughput: one command at a time; s_tready is high only while the
// sequencer is idle. A finished result sits in the output register, so the
// next command may be taken while that result waits for the receiver.
// Stall: if m_tready stays low, the result holds and the next finished
// result waits in the sequencer until the output register is free.
// Reset: aresetn low at a clock edge empties the buffer (length zero) and
// drops any pending result. The byte store itself is not cleared; only
// entries below the length are ever read.
module char_buffer_block_delete (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // op [1:0], char_value [9:2], left [17:10], right [25:18],
    // read_position [33:26], zero fill [39:34]
    input  logic [39:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // read_char [7:0], length [16:8], status [18:17], zero fill [23:19]
    output logic [23:0] m_tdata
);

    cbbd_pkg::mem_req_t mem_req;
    logic [7:0]         mem_rdata;
    logic               res_valid;
    logic               res_ready;
    cbbd_pkg::result_t  res;

    logic               out_valid_reg;
    cbbd_pkg::result_t  out_data_reg;

    cbbd_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .op            (s_tdata[1:0]),
        .char_value    (s_tdata[9:2]),
        .left          (s_tdata[17:10]),
        .right         (s_tdata[25:18]),
        .read_position (s_tdata[33:26]),
        .mem_req       (mem_req),
        .mem_rdata     (mem_rdata),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .res           (res)
    );

    cbbd_ram u_ram (
        .aclk  (aclk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    // The output register takes a new result when it is empty or its
    // current beat leaves in this cycle.
    assign res_ready = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (res_ready) begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            out_data_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_data_reg.status, out_data_reg.length,
                       out_data_reg.read_char};

endmodule

// ----- rtl/cbbd_ram.sv -----
// Byte store of the character buffer: one write port, one read port with
// registered read data. Depends on cbbd_pkg.
module cbbd_ram (
    input  logic               aclk,
    input  cbbd_pkg::mem_req_t req,
    output logic [7:0]         rdata
);

    logic [7:0] mem [cbbd_pkg::DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re) begin
            rdata_reg <= mem[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/cbbd_ctrl.sv -----
// Sequencer of the character buffer: keeps the fill count and walks the
// byte store one entry at a time through a read/write step pair.
// Depends on cbbd_pkg.
module cbbd_ctrl (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [1:0]                op,
    input  logic [7:0]                char_value,
    input  logic [7:0]                left,
    input  logic [7:0]                right,
    input  logic [7:0]                read_position,
    output cbbd_pkg::mem_req_t        mem_req,
    input  logic [7:0]                mem_rdata,
    output logic                      res_valid,
    input  logic                      res_ready,
    output cbbd_pkg::result_t         res
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_RD    = 3'd2;
    localparam logic [2:0] S_WR    = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    localparam int AW = cbbd_pkg::ADDR_W;
    localparam int CW = cbbd_pkg::CNT_W;
    localparam logic [CW-1:0] DEPTH_C = CW'(cbbd_pkg::DEPTH);

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic [CW-1:0] src_reg, src_next;
    logic [CW-1:0] dst_reg, dst_next;
    logic [1:0]    op_reg;
    logic [7:0]    ch_reg, lo_reg, hi_reg, pos_reg;
    logic [1:0]    status_reg, status_next;
    logic [7:0]    rchar_reg, rchar_next;
    logic [CW-1:0] hi_ext;

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign hi_ext    = {1'b0, hi_reg};

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            op_reg  <= op;
            ch_reg  <= char_value;
            lo_reg  <= left;
            hi_reg  <= right;
            pos_reg <= read_position;
        end
        src_reg    <= src_next;
        dst_reg    <= dst_next;
        status_reg <= status_next;
        rchar_reg  <= rchar_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            fill_reg  <= '0;
        end else begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        fill_next     = fill_reg;
        src_next      = src_reg;
        dst_next      = dst_reg;
        status_next   = status_reg;
        rchar_next    = rchar_reg;
        mem_req.we    = 1'b0;
        mem_req.waddr = dst_reg[AW-1:0];
        mem_req.wdata = mem_rdata;
        mem_req.re    = 1'b0;
        mem_req.raddr = src_reg[AW-1:0];
        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    state_next  = S_START;
                    status_next = cbbd_pkg::ST_OK;
                    rchar_next  = 8'd0;
                end
            end
            S_START: begin
                case (op_reg)
                    cbbd_pkg::OP_APPEND: begin
                        state_next = S_DONE;
                        if (fill_reg < DEPTH_C) begin
                            mem_req.we    = 1'b1;
                            mem_req.waddr = fill_reg[AW-1:0];
                            mem_req.wdata = ch_reg;
                            fill_next     = fill_reg + CW'(1);
                        end else begin
                            status_next = cbbd_pkg::ST_FULL;
                        end
                    end
                    cbbd_pkg::OP_DELETE: begin
                        if (lo_reg > hi_reg || hi_ext >= fill_reg) begin
                            status_next = cbbd_pkg::ST_BAD;
                            state_next  = S_DONE;
                        end else begin
                            src_next   = hi_ext + CW'(1);
                            dst_next   = {1'b0, lo_reg};
                            state_next = S_RD;
                        end
                    end
                    cbbd_pkg::OP_REMOVE: begin
                        src_next   = '0;
                        dst_next   = '0;
                        state_next = S_RD;
                    end
                    default: begin
                        if ({1'b0, pos_reg} < fill_reg) begin
                            src_next   = {1'b0, pos_reg};
                            state_next = S_RD;
                        end else begin
                            status_next = cbbd_pkg::ST_BAD;
                            state_next  = S_DONE;
                        end
                    end
                endcase
            end
            S_RD: begin
                // A read always has its position below the fill count, so
                // only the moving operations ever leave through this end test.
                if (src_reg >= fill_reg) begin
                    fill_next  = dst_reg;
                    state_next = S_DONE;
                end else begin
                    mem_req.re = 1'b1;
                    state_next = S_WR;
                end
            end
            S_WR: begin
                if (op_reg == cbbd_pkg::OP_READ) begin
                    rchar_next = mem_rdata;
                    state_next = S_DONE;
                end else begin
                    if (op_reg == cbbd_pkg::OP_DELETE || mem_rdata != ch_reg) begin
                        mem_req.we = 1'b1;
                        dst_next   = dst_reg + CW'(1);
                    end
                    src_next   = src_reg + CW'(1);
                    state_next = S_RD;
                end
            end
            S_DONE: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign res.read_char = rchar_reg;
    assign res.length    = fill_reg;
    assign res.status    = status_reg;

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= DEPTH_C)
        else $error("fill count above depth");

    a_dst_behind: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RD || state_reg == S_WR) && op_reg != cbbd_pkg::OP_READ
        |-> dst_reg <= src_reg)
        else $error("write pointer passed read pointer");

    a_we_states: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_req.we |-> (state_reg == S_START || state_reg == S_WR))
        else $error("memory write outside a write step");

    a_done_leaves: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE && res_ready) |=> state_reg == S_IDLE)
        else $error("result taken but sequencer did not return to idle");

endmodule
